// ===== rtl/core/mjg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjg_pkg - shared codes and types of the maze junction graph solver
// Result status codes, configuration register indexes and the status word
// that the graph builder hands to the search sequencer.
// ----------------------------------------------------------------------------
package mjg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END_ROW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_COL   = 3'd5;

	localparam logic [1:0] ST_NODE     = 2'd0;
	localparam logic [1:0] ST_NOPATH   = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam int NODE_IDX_W = 6;
	localparam int NODE_CNT_W = 7;
	localparam int CRD_W      = 8;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [1:0]            status;
		logic [NODE_CNT_W-1:0] total;
		logic [NODE_IDX_W-1:0] sidx;
		logic [NODE_IDX_W-1:0] eidx;
		logic                  nb_we;
		logic [NODE_IDX_W-1:0] nb_idx;
	} bld_stat_t;

endpackage

// ===== rtl/core/mjg_build.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjg_build - grid store, node marking and neighbor linking
// Holds the cell grid, marks nodes by reading each cell and its four neighbors
// in turn, then walks straight probes from each node to find up to four links.
// ----------------------------------------------------------------------------
module mjg_build #(
	parameter int MAX_ROWS,
	parameter int MAX_COLS,
	parameter int MAX_NODES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cell_take,
	input  logic                          cell_open,
	input  logic [mjg_pkg::CFG_DATA_W-1:0] rows_cfg,
	input  logic [mjg_pkg::CFG_DATA_W-1:0] cols_cfg,
	input  logic [4:0]                    srow,
	input  logic [4:0]                    scol,
	input  logic [4:0]                    erow,
	input  logic [4:0]                    ecol,
	input  logic [mjg_pkg::NODE_IDX_W-1:0] crd_addr,
	output logic [mjg_pkg::CRD_W-1:0]      crd_row,
	output logic [mjg_pkg::CRD_W-1:0]      crd_col,
	output logic [MAX_NODES-1:0]          nb_row,
	output mjg_pkg::bld_stat_t            stat
);
	import mjg_pkg::*;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int NR_W   = ROW_W + 1;
	localparam int NC_W   = COL_W + 1;
	localparam int CELLS  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_MARK  = 3'd1;
	localparam logic [2:0] B_LLOAD = 3'd2;
	localparam logic [2:0] B_LSET  = 3'd3;
	localparam logic [2:0] B_PSTEP = 3'd4;
	localparam logic [2:0] B_PCHK  = 3'd5;
	localparam logic [2:0] B_DONE  = 3'd6;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
	endfunction

	logic [2:0]       state_q;
	logic [ROW_W-1:0] lr_q, mr_q, hr_q, py_q;
	logic [COL_W-1:0] lc_q, mc_q, hc_q, px_q;
	logic [2:0]       ms_q;
	logic             self_q;
	logic [2:0]       nbr_q;
	logic [CNT_W-1:0] total_q, li_q;
	logic [IDX_W-1:0] sidx_q, eidx_q;
	logic [1:0]       status_q, dir_q;
	logic [MAX_NODES-1:0] acc_q;
	logic             nbwe_q;
	logic [IDX_W-1:0] nbidx_q;
	logic [MAX_NODES-1:0] nbrow_q;

	logic                 open_mem [CELLS];
	logic [CNT_W-1:0]     id_mem   [CELLS];
	logic [ROW_W+COL_W-1:0] crd_mem [MAX_NODES];
	logic                 op_rd_q;
	logic [CNT_W-1:0]     id_rd_q;
	logic [ROW_W+COL_W-1:0] crd_rd_q;

	logic [NR_W-1:0]   nr;
	logic [NC_W-1:0]   nc;
	logic [ROW_W-1:0]  rmax, ny;
	logic [COL_W-1:0]  cmax, nx;
	logic              hl, hrt, hu, hd, dn, can_move;
	logic [2:0]        ocnt;
	logic              mark, is_se_m, is_se_p, grid_out;
	logic [ADDR_W-1:0] op_raddr, self_addr;
	logic [IDX_W-1:0]  crd_raddr;
	logic              restart;
	logic [ROW_W-1:0]  wr_r;
	logic [COL_W-1:0]  wr_c;

	// effective grid size: zero acts as one, saturate at the maximum
	always_comb begin
		if (rows_cfg == '0) nr = NR_W'(1);
		else if (32'(rows_cfg) > MAX_ROWS) nr = NR_W'(MAX_ROWS);
		else nr = NR_W'(rows_cfg);
		if (cols_cfg == '0) nc = NC_W'(1);
		else if (32'(cols_cfg) > MAX_COLS) nc = NC_W'(MAX_COLS);
		else nc = NC_W'(cols_cfg);
		rmax = ROW_W'(nr - NR_W'(1));
		cmax = COL_W'(nc - NC_W'(1));
	end

	assign is_se_m = (32'(mr_q) == 32'(srow) && 32'(mc_q) == 32'(scol)) ||
		(32'(mr_q) == 32'(erow) && 32'(mc_q) == 32'(ecol));
	assign is_se_p = (32'(py_q) == 32'(srow) && 32'(px_q) == 32'(scol)) ||
		(32'(py_q) == 32'(erow) && 32'(px_q) == 32'(ecol));
	assign grid_out = 32'(srow) >= 32'(nr) || 32'(scol) >= 32'(nc) ||
		32'(erow) >= 32'(nr) || 32'(ecol) >= 32'(nc);

	// neighbor bounds of the marking position
	assign hl  = mc_q != '0;
	assign hrt = 32'(mc_q) + 1 < 32'(nc);
	assign hu  = mr_q != '0;
	assign hd  = 32'(mr_q) + 1 < 32'(nr);
	assign dn  = hd & op_rd_q;
	assign self_addr = cell_addr(mr_q, mc_q);

	always_comb begin
		logic hcor, vcor;
		ocnt = 3'(nbr_q[0]) + 3'(nbr_q[1]) + 3'(nbr_q[2]) + 3'(dn);
		hcor = nbr_q[0] && nbr_q[1] && !(nbr_q[2] || dn);
		vcor = nbr_q[2] && dn && !(nbr_q[0] || nbr_q[1]);
		mark = is_se_m || (self_q && ocnt >= 3'd2 && !(hcor || vcor));
	end

	// probe step: 0 up, 1 down, 2 left, 3 right
	always_comb begin
		ny = py_q;
		nx = px_q;
		can_move = 1'b0;
		case (dir_q)
			2'd0: begin
				ny = ROW_W'(py_q - 1'b1);
				can_move = py_q != '0;
			end
			2'd1: begin
				ny = ROW_W'(py_q + 1'b1);
				can_move = 32'(py_q) + 1 < 32'(nr);
			end
			2'd2: begin
				nx = COL_W'(px_q - 1'b1);
				can_move = px_q != '0;
			end
			default: begin
				nx = COL_W'(px_q + 1'b1);
				can_move = 32'(px_q) + 1 < 32'(nc);
			end
		endcase
	end

	always_comb begin
		op_raddr = self_addr;
		if (state_q == B_MARK) begin
			case (ms_q)
				3'd1: op_raddr = hl ? cell_addr(mr_q, COL_W'(mc_q - 1'b1)) : self_addr;
				3'd2: op_raddr = hrt ? cell_addr(mr_q, COL_W'(mc_q + 1'b1)) : self_addr;
				3'd3: op_raddr = hu ? cell_addr(ROW_W'(mr_q - 1'b1), mc_q) : self_addr;
				3'd4: op_raddr = hd ? cell_addr(ROW_W'(mr_q + 1'b1), mc_q) : self_addr;
				default: op_raddr = self_addr;
			endcase
		end else if (state_q == B_PSTEP) begin
			op_raddr = cell_addr(ny, nx);
		end
	end

	assign restart = 32'(lr_q) >= 32'(nr);
	assign wr_r = restart ? '0 : lr_q;
	assign wr_c = restart ? '0 : lc_q;
	assign crd_raddr = (state_q == B_LLOAD) ? IDX_W'(li_q) : IDX_W'(crd_addr);

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && cell_take) open_mem[cell_addr(wr_r, wr_c)] <= cell_open;
		if (state_q == B_MARK && ms_q == 3'd5 && !(mark && 32'(total_q) >= MAX_NODES)) begin
			id_mem[self_addr] <= mark ? CNT_W'(total_q + 1'b1) : '0;
			if (mark) crd_mem[IDX_W'(total_q)] <= {mr_q, mc_q};
		end
		op_rd_q  <= open_mem[op_raddr];
		id_rd_q  <= id_mem[op_raddr];
		crd_rd_q <= crd_mem[crd_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			lr_q     <= '0;
			lc_q     <= '0;
			mr_q     <= '0;
			mc_q     <= '0;
			ms_q     <= '0;
			total_q  <= '0;
			li_q     <= '0;
			dir_q    <= '0;
			status_q <= ST_NODE;
			nbwe_q   <= 1'b0;
		end else begin
			nbwe_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (cell_take) begin
						if (wr_r == rmax && wr_c == cmax) begin
							lr_q    <= '0;
							lc_q    <= '0;
							mr_q    <= '0;
							mc_q    <= '0;
							ms_q    <= '0;
							total_q <= '0;
							state_q <= B_MARK;
						end else if (wr_c == cmax) begin
							lr_q <= ROW_W'(wr_r + 1'b1);
							lc_q <= '0;
						end else begin
							lr_q <= wr_r;
							lc_q <= COL_W'(wr_c + 1'b1);
						end
					end
				end
				B_MARK: begin
					case (ms_q)
						3'd1: self_q   <= op_rd_q;
						3'd2: nbr_q[0] <= hl & op_rd_q;
						3'd3: nbr_q[1] <= hrt & op_rd_q;
						3'd4: nbr_q[2] <= hu & op_rd_q;
						default: ;
					endcase
					if (ms_q != 3'd5) begin
						ms_q <= ms_q + 3'd1;
					end else begin
						ms_q <= '0;
						if (mark && 32'(total_q) >= MAX_NODES) begin
							status_q <= ST_OVERFLOW;
							state_q  <= B_DONE;
						end else begin
							if (mark) begin
								total_q <= CNT_W'(total_q + 1'b1);
								if (32'(mr_q) == 32'(srow) && 32'(mc_q) == 32'(scol))
									sidx_q <= IDX_W'(total_q);
								if (32'(mr_q) == 32'(erow) && 32'(mc_q) == 32'(ecol))
									eidx_q <= IDX_W'(total_q);
							end
							if (mr_q == rmax && mc_q == cmax) begin
								li_q <= '0;
								if (grid_out) begin
									status_q <= ST_NOPATH;
									state_q  <= B_DONE;
								end else begin
									state_q <= B_LLOAD;
								end
							end else if (mc_q == cmax) begin
								mr_q <= ROW_W'(mr_q + 1'b1);
								mc_q <= '0;
							end else begin
								mc_q <= COL_W'(mc_q + 1'b1);
							end
						end
					end
				end
				B_LLOAD: state_q <= B_LSET;
				B_LSET: begin
					hr_q    <= crd_rd_q[ROW_W+COL_W-1:COL_W];
					hc_q    <= crd_rd_q[COL_W-1:0];
					py_q    <= crd_rd_q[ROW_W+COL_W-1:COL_W];
					px_q    <= crd_rd_q[COL_W-1:0];
					dir_q   <= '0;
					acc_q   <= '0;
					state_q <= B_PSTEP;
				end
				B_PSTEP, B_PCHK: begin
					logic             dir_end, hit;
					logic [MAX_NODES-1:0] acc_n;
					dir_end = 1'b0;
					hit     = 1'b0;
					if (state_q == B_PSTEP) begin
						if (can_move) begin
							py_q    <= ny;
							px_q    <= nx;
							state_q <= B_PCHK;
						end else begin
							dir_end = 1'b1;
						end
					end else if (!op_rd_q && !is_se_p) begin
						dir_end = 1'b1;
					end else if (id_rd_q != '0) begin
						dir_end = 1'b1;
						hit     = 1'b1;
					end else begin
						state_q <= B_PSTEP;
					end
					acc_n = acc_q;
					if (hit) acc_n = acc_q | (MAX_NODES'(1) << IDX_W'(id_rd_q - 1'b1));
					acc_q <= acc_n;
					if (dir_end) begin
						if (dir_q == 2'd3) begin
							nbwe_q  <= 1'b1;
							nbidx_q <= IDX_W'(li_q);
							nbrow_q <= acc_n;
							li_q    <= CNT_W'(li_q + 1'b1);
							if (CNT_W'(li_q + 1'b1) == total_q) begin
								status_q <= ST_NODE;
								state_q  <= B_DONE;
							end else begin
								state_q <= B_LLOAD;
							end
						end else begin
							dir_q   <= dir_q + 2'd1;
							py_q    <= hr_q;
							px_q    <= hc_q;
							state_q <= B_PSTEP;
						end
					end
				end
				B_DONE: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign crd_row = CRD_W'(crd_rd_q[ROW_W+COL_W-1:COL_W]);
	assign crd_col = CRD_W'(crd_rd_q[COL_W-1:0]);
	assign nb_row  = nbrow_q;

	always_comb begin
		stat        = '0;
		stat.busy   = state_q != B_IDLE;
		stat.done   = state_q == B_DONE;
		stat.status = status_q;
		stat.total  = NODE_CNT_W'(total_q);
		stat.sidx   = NODE_IDX_W'(sidx_q);
		stat.eidx   = NODE_IDX_W'(eidx_q);
		stat.nb_we  = nbwe_q;
		stat.nb_idx = NODE_IDX_W'(nbidx_q);
	end

endmodule

// ===== rtl/core/maze_junction_graph_dfs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_junction_graph_dfs - maze solver over a junction graph
// Loads a grid, builds the junction graph and emits a depth-first path.
// ----------------------------------------------------------------------------
// Cells load one word per cycle in row-major order; cell_stall stays low
// while the block is waiting for cells. The word that completes the grid
// starts a solve and cell_stall rises until the last result is taken. The
// solve marks nodes first (one grid memory read port, six reads per
// cell), then fetches the position of each node and steps its four
// straight probes cell by cell, then lets the search sequencer examine
// one candidate at a time, going through T_NB after each push and through
// T_POP and T_NB after each pop, and finally sends each path word through
// T_ORD, T_OCRD, T_OSET and T_OUT, where it waits out any output stall.
// Configuration is always ready and must be written only while the
// block is idle. No memory is cleared after reset: each solve rewrites every
// grid entry it reads.
// ----------------------------------------------------------------------------
module maze_junction_graph_dfs #(
	parameter int MAX_ROWS  = 32,
	parameter int MAX_COLS  = 32,
	parameter int MAX_NODES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cell_valid,
	output logic                          cell_stall,
	input  logic                          cell_open,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    status,
	output logic [5:0]                    node_index,
	output logic [4:0]                    node_row,
	output logic [4:0]                    node_col,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mjg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mjg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mjg_pkg::*;

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_NB   = 3'd1;
	localparam logic [2:0] T_SCAN = 3'd2;
	localparam logic [2:0] T_POP  = 3'd3;
	localparam logic [2:0] T_ORD  = 3'd4;
	localparam logic [2:0] T_OCRD = 3'd5;
	localparam logic [2:0] T_OSET = 3'd6;
	localparam logic [2:0] T_OUT  = 3'd7;

	// configuration registers
	logic [CFG_DATA_W-1:0] rows_q, cols_q;
	logic [4:0]            srow_q, scol_q, erow_q, ecol_q;

	bld_stat_t             bs;
	logic [MAX_NODES-1:0]  nb_wrow;
	logic [CRD_W-1:0]      crd_row, crd_col;
	logic                  cell_take;

	logic [2:0]            t_state_q;
	logic [CNT_W-1:0]      depth_q, try_q, total_q;
	logic [IDX_W-1:0]      s_q, eidx_q, oi_q, n_q;
	logic [MAX_NODES-1:0]  vis_q;

	logic [MAX_NODES-1:0]  nb_mem [MAX_NODES];
	logic [IDX_W-1:0]      ps_mem [MAX_NODES];
	logic [CNT_W-1:0]      nt_mem [MAX_NODES];
	logic [MAX_NODES-1:0]  nb_rd_q;
	logic [IDX_W-1:0]      ps_rd_q;
	logic [CNT_W-1:0]      nt_rd_q;

	logic                  ps_we, nt_we;
	logic [IDX_W-1:0]      ps_waddr, ps_wdata, nt_waddr, ps_raddr, ti, bs_sidx;
	logic [CNT_W-1:0]      nt_wdata;
	logic                  cand, scan_end;

	logic                  rv_q, last_q;
	logic [1:0]            st_q;
	logic [5:0]            idx_q;
	logic [4:0]            row_q, col_q;

	assign cfg_ready  = 1'b1;
	// hold off cells while the graph is built, searched or emitted
	assign cell_stall = bs.busy || (t_state_q != T_IDLE);
	assign cell_take  = cell_valid && !cell_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 6'd32;
			cols_q <= 6'd32;
			srow_q <= 5'd0;
			scol_q <= 5'd0;
			erow_q <= 5'd31;
			ecol_q <= 5'd31;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS:      rows_q <= cfg_data;
				REG_COLS:      cols_q <= cfg_data;
				REG_START_ROW: srow_q <= cfg_data[4:0];
				REG_START_COL: scol_q <= cfg_data[4:0];
				REG_END_ROW:   erow_q <= cfg_data[4:0];
				REG_END_COL:   ecol_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	mjg_build #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_NODES(MAX_NODES)
	) u_build (
		.clk      (clk),
		.arst_n   (arst_n),
		.cell_take(cell_take),
		.cell_open(cell_open),
		.rows_cfg (rows_q),
		.cols_cfg (cols_q),
		.srow     (srow_q),
		.scol     (scol_q),
		.erow     (erow_q),
		.ecol     (ecol_q),
		.crd_addr (NODE_IDX_W'(ps_rd_q)),
		.crd_row  (crd_row),
		.crd_col  (crd_col),
		.nb_row   (nb_wrow),
		.stat     (bs)
	);

	// candidate test of the search: one neighbor index per cycle in T_SCAN
	assign ti       = try_q[IDX_W-1:0];
	assign cand     = nb_rd_q[ti] && !vis_q[ti];
	assign scan_end = try_q >= total_q;
	assign bs_sidx  = IDX_W'(bs.sidx);

	always_comb begin
		ps_we    = 1'b0;
		ps_waddr = '0;
		ps_wdata = bs_sidx;
		nt_we    = 1'b0;
		nt_waddr = IDX_W'(depth_q - 1'b1);
		nt_wdata = CNT_W'(try_q + 1'b1);
		ps_raddr = oi_q;
		if (t_state_q == T_IDLE && bs.done && bs.status == ST_NODE) begin
			ps_we = 1'b1;
		end
		if (t_state_q == T_SCAN) begin
			if (scan_end) begin
				ps_raddr = IDX_W'(depth_q - CNT_W'(2));
			end else if (cand) begin
				ps_we    = 1'b1;
				ps_waddr = IDX_W'(depth_q);
				ps_wdata = ti;
				nt_we    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bs.nb_we) nb_mem[IDX_W'(bs.nb_idx)] <= nb_wrow;
		if (ps_we) ps_mem[ps_waddr] <= ps_wdata;
		if (nt_we) nt_mem[nt_waddr] <= nt_wdata;
		nb_rd_q <= nb_mem[s_q];
		ps_rd_q <= ps_mem[ps_raddr];
		nt_rd_q <= nt_mem[ps_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_state_q <= T_IDLE;
			depth_q   <= '0;
			try_q     <= '0;
			total_q   <= '0;
			s_q       <= '0;
			oi_q      <= '0;
			rv_q      <= 1'b0;
		end else begin
			case (t_state_q)
				T_IDLE: begin
					if (bs.done) begin
						if (bs.status != ST_NODE) begin
							// status word: no path or too many nodes
							st_q      <= bs.status;
							idx_q     <= '0;
							row_q     <= '0;
							col_q     <= '0;
							last_q    <= 1'b1;
							rv_q      <= 1'b1;
							t_state_q <= T_OUT;
						end else begin
							depth_q <= CNT_W'(1);
							s_q     <= bs_sidx;
							eidx_q  <= IDX_W'(bs.eidx);
							total_q <= CNT_W'(bs.total);
							try_q   <= '0;
							oi_q    <= '0;
							vis_q   <= MAX_NODES'(1) << bs_sidx;
							if (bs.sidx == bs.eidx) t_state_q <= T_ORD;
							else t_state_q <= T_NB;
						end
					end
				end
				T_NB: t_state_q <= T_SCAN;
				T_SCAN: begin
					if (scan_end) begin
						// backtrack: drop the top entry
						if (depth_q == CNT_W'(1)) begin
							st_q      <= ST_NOPATH;
							idx_q     <= '0;
							row_q     <= '0;
							col_q     <= '0;
							last_q    <= 1'b1;
							rv_q      <= 1'b1;
							t_state_q <= T_OUT;
						end else begin
							depth_q   <= CNT_W'(depth_q - 1'b1);
							t_state_q <= T_POP;
						end
					end else if (cand) begin
						depth_q <= CNT_W'(depth_q + 1'b1);
						s_q     <= ti;
						try_q   <= '0;
						if (ti == eidx_q) begin
							oi_q      <= IDX_W'(depth_q);
							t_state_q <= T_ORD;
						end else begin
							vis_q[ti] <= 1'b1;
							t_state_q <= T_NB;
						end
					end else begin
						try_q <= CNT_W'(try_q + 1'b1);
					end
				end
				T_POP: begin
					s_q       <= ps_rd_q;
					try_q     <= nt_rd_q;
					t_state_q <= T_NB;
				end
				T_ORD:  t_state_q <= T_OCRD;
				T_OCRD: begin
					n_q       <= ps_rd_q;
					t_state_q <= T_OSET;
				end
				T_OSET: begin
					st_q      <= ST_NODE;
					idx_q     <= 6'(n_q);
					row_q     <= 5'(crd_row);
					col_q     <= 5'(crd_col);
					last_q    <= oi_q == '0;
					rv_q      <= 1'b1;
					t_state_q <= T_OUT;
				end
				T_OUT: begin
					if (!result_stall) begin
						rv_q <= 1'b0;
						if (last_q) begin
							t_state_q <= T_IDLE;
						end else begin
							oi_q      <= IDX_W'(oi_q - 1'b1);
							t_state_q <= T_ORD;
						end
					end
				end
				default: t_state_q <= T_IDLE;
			endcase
		end
	end

	assign result_valid = rv_q;
	assign status       = st_q;
	assign node_index   = idx_q;
	assign node_row     = row_q;
	assign node_col     = col_q;
	assign last         = last_q;

	// a status word other than a path node always closes the solve
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_NODE) |-> last)
		else $error("status word without last");

	// the builder only finishes while the search side is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bs.done |-> (t_state_q == T_IDLE))
		else $error("build done while search busy");

	// the search stack never runs empty or past the node limit
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(t_state_q == T_SCAN) |-> (depth_q != '0 && 32'(depth_q) <= MAX_NODES))
		else $error("stack depth out of range");

	// no cell is taken while a result word waits
	a_out_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cell_stall)
		else $error("cell accepted during output");

endmodule

// ===== verif/maze_junction_graph_dfs_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_junction_graph_dfs_tb - self-checking bench of the junction graph solver
// Loads mazes cell by cell, solves each one in a behavioral predictor and
// compares every path word against the block under random handshake idling.
// ----------------------------------------------------------------------------
module maze_junction_graph_dfs_tb;
	import mjg_pkg::*;

	localparam int GRID_W     = 32;
	localparam int NODE_LIMIT = 64;
	localparam int WDOG_LIMIT = 200000;

	typedef struct packed {
		logic [1:0] st;
		logic [5:0] idx;
		logic [4:0] row;
		logic [4:0] col;
		logic       lst;
	} path_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cell_valid;
	logic                  cell_stall;
	logic                  cell_open;
	logic                  result_valid;
	logic                  result_stall;
	logic [1:0]            status;
	logic [5:0]            node_index;
	logic [4:0]            node_row;
	logic [4:0]            node_col;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the block: grid, fill pointer and register values.
	bit         maze_grid [GRID_W*GRID_W];
	int         fill_pos;
	int         rows_reg, cols_reg, srow_reg, scol_reg, erow_reg, ecol_reg;
	path_word_t path_q[$];

	int  err_count;
	int  cells_sent;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  quiet_cycles;

	maze_junction_graph_dfs u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.cell_open   (cell_open),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status      (status),
		.node_index  (node_index),
		.node_row    (node_row),
		.node_col    (node_col),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// A zero size acts as one; anything above the grid saturates.
	function automatic int clamp_size(int v);
		if (v == 0) return 1;
		return (v > GRID_W) ? GRID_W : v;
	endfunction

	function automatic bit is_endpoint(int r, int c);
		return (r == srow_reg && c == scol_reg) || (r == erow_reg && c == ecol_reg);
	endfunction

	function automatic void push_word(logic [1:0] st, int idx, int r, int c, bit l);
		path_word_t w;
		w.st  = st;
		w.idx = idx[5:0];
		w.row = r[4:0];
		w.col = c[4:0];
		w.lst = l;
		path_q = {path_q, w};
	endfunction

	// Mark junctions, link them along the four axes, then search depth first
	// and queue the path from goal back to start.
	function automatic void solve_maze();
		int nr, nc, r, c, i, k, y, x, hit, total, sidx, eidx, depth, top, s;
		int pl, pr, pu, pd;
		int idmap [GRID_W*GRID_W];
		int coords [NODE_LIMIT];
		int stk [NODE_LIMIT];
		int nxt [NODE_LIMIT];
		int drs [4];
		int dcs [4];
		bit [NODE_LIMIT-1:0] nbr [NODE_LIMIT];
		bit [NODE_LIMIT-1:0] seen;
		bit found, pushed, mark, hcor, vcor;
		nr = clamp_size(rows_reg);
		nc = clamp_size(cols_reg);
		drs = '{-1, 1, 0, 0};
		dcs = '{0, 0, -1, 1};
		total = 0;
		for (i = 0; i < GRID_W*GRID_W; i++) idmap[i] = 0;
		for (r = 0; r < nr; r++) begin
			for (c = 0; c < nc; c++) begin
				pl = (c > 0 && maze_grid[r*GRID_W + c-1]) ? 1 : 0;
				pr = (c + 1 < nc && maze_grid[r*GRID_W + c+1]) ? 1 : 0;
				pu = (r > 0 && maze_grid[(r-1)*GRID_W + c]) ? 1 : 0;
				pd = (r + 1 < nr && maze_grid[(r+1)*GRID_W + c]) ? 1 : 0;
				hcor = pl && pr && !(pu || pd);
				vcor = pu && pd && !(pl || pr);
				mark = is_endpoint(r, c) || (maze_grid[r*GRID_W + c] &&
					(pl + pr + pu + pd) >= 2 && !(hcor || vcor));
				if (!mark) continue;
				if (total >= NODE_LIMIT) begin
					push_word(ST_OVERFLOW, 0, 0, 0, 1'b1);
					return;
				end
				coords[total] = r*GRID_W + c;
				total++;
				idmap[r*GRID_W + c] = total;
			end
		end
		for (i = 0; i < total; i++) begin
			nbr[i] = '0;
			for (k = 0; k < 4; k++) begin
				y = coords[i] / GRID_W + drs[k];
				x = coords[i] % GRID_W + dcs[k];
				hit = 0;
				while (y >= 0 && x >= 0 && y < nr && x < nc) begin
					if (!maze_grid[y*GRID_W + x] && !is_endpoint(y, x)) break;
					if (idmap[y*GRID_W + x] != 0) begin
						hit = idmap[y*GRID_W + x];
						break;
					end
					y += drs[k];
					x += dcs[k];
				end
				if (hit != 0) nbr[i][hit-1] = 1'b1;
			end
		end
		if (srow_reg >= nr || scol_reg >= nc || erow_reg >= nr || ecol_reg >= nc) begin
			push_word(ST_NOPATH, 0, 0, 0, 1'b1);
			return;
		end
		sidx = idmap[srow_reg*GRID_W + scol_reg] - 1;
		eidx = idmap[erow_reg*GRID_W + ecol_reg] - 1;
		seen = '0;
		stk[0] = sidx;
		nxt[0] = 0;
		depth = 1;
		found = (sidx == eidx);
		if (!found) seen[sidx] = 1'b1;
		while (depth > 0 && !found) begin
			top = depth - 1;
			s = stk[top];
			pushed = 1'b0;
			for (i = nxt[top]; i < total; i++) begin
				if (nbr[s][i] && !seen[i]) begin
					nxt[top] = i + 1;
					stk[depth] = i;
					nxt[depth] = 0;
					depth++;
					if (i == eidx) found = 1'b1;
					else seen[i] = 1'b1;
					pushed = 1'b1;
					break;
				end
			end
			if (!pushed) depth--;
		end
		if (!found) begin
			push_word(ST_NOPATH, 0, 0, 0, 1'b1);
			return;
		end
		for (k = 0; k < depth; k++) begin
			s = stk[depth - 1 - k];
			push_word(ST_NODE, s, coords[s] / GRID_W, coords[s] % GRID_W, k + 1 == depth);
		end
	endfunction

	// Place one cell; the cell that completes the grid triggers a solve.
	function automatic void predict_cell(bit v);
		int nc, tot;
		nc = clamp_size(cols_reg);
		tot = clamp_size(rows_reg) * nc;
		if (fill_pos >= tot) fill_pos = 0;
		maze_grid[(fill_pos / nc)*GRID_W + fill_pos % nc] = v;
		fill_pos++;
		if (fill_pos < tot) return;
		fill_pos = 0;
		solve_maze();
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	// Send one cell word. Valid stays high after acceptance so that back to
	// back words never drop it; a gap lowers it at the next call.
	task automatic send_cell(bit v);
		bit took;
		while ($urandom_range(99) < send_idle_pct) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_open  <= v;
		// sample stall mid-cycle, where it has settled for the coming edge
		do begin
			@(negedge clk);
			took = !cell_stall;
			@(posedge clk);
		end while (!took);
		predict_cell(v);
		cells_sent++;
	endtask

	// Hold the sender until every expected word is back, then let the
	// block settle before the next register write.
	task automatic drain();
		cell_valid <= 1'b0;
		@(posedge clk);
		while (path_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ROWS:      rows_reg = val & 63;
			REG_COLS:      cols_reg = val & 63;
			REG_START_ROW: srow_reg = val & 31;
			REG_START_COL: scol_reg = val & 31;
			REG_END_ROW:   erow_reg = val & 31;
			REG_END_COL:   ecol_reg = val & 31;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_maze(int rows, int cols, int sr, int sc, int er, int ec);
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
		write_reg(REG_START_ROW, sr);
		write_reg(REG_START_COL, sc);
		write_reg(REG_END_ROW, er);
		write_reg(REG_END_COL, ec);
	endtask

	// Send a pattern given as a bit string, first cell in the lowest bit.
	task automatic send_pattern(int n, logic [63:0] pat);
		int i;
		for (i = 0; i < n; i++) send_cell(pat[i]);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// One full-width row, all open: only the two endpoints become nodes.
	task automatic test_wide_row();
		set_maze(1, 32, 0, 0, 0, 31);
		send_pattern(32, {64{1'b1}});
		drain();
	endtask

	// Zero sizes act as a single cell; start on end on a wall.
	task automatic test_single_cell();
		set_maze(0, 0, 0, 0, 0, 0);
		send_cell(1'b0);
		drain();
	endtask

	// Endpoints on walls are still nodes and reachable.
	task automatic test_wall_endpoints();
		set_maze(3, 3, 0, 0, 2, 2);
		send_pattern(9, 9'b011_111_110);
		drain();
	endtask

	// Diagonal walls split start from goal.
	task automatic test_no_path();
		set_maze(2, 2, 0, 0, 1, 1);
		send_pattern(4, 4'b1001);
		drain();
	endtask

	// Start outside the grid answers no path.
	task automatic test_start_outside();
		set_maze(2, 2, 31, 0, 1, 1);
		send_pattern(4, 4'b1111);
		drain();
	endtask

	// Shrink the row count mid-load so the load restarts at cell 0.
	task automatic test_shrink_restart();
		set_maze(4, 3, 0, 0, 1, 2);
		send_pattern(6, 6'b101101);
		drain();
		write_reg(REG_ROWS, 2);
		send_pattern(6, 6'b111111);
		drain();
	endtask

	// An all-open 9x9 grid marks every cell: more nodes than fit.
	task automatic test_node_overflow();
		int i;
		set_maze(9, 9, 0, 0, 8, 8);
		for (i = 0; i < 81; i++) send_cell(1'b1);
		drain();
	endtask

	// Oversized counts saturate: 63 rows act as 32, then 40 columns as 32.
	task automatic test_full_grid();
		int i;
		set_maze(63, 4, 0, 0, 31, 3);
		for (i = 0; i < GRID_W*4; i++) send_cell($urandom_range(99) < 70);
		drain();
		set_maze(1, 40, 0, 0, 0, 31);
		for (i = 0; i < GRID_W; i++) send_cell($urandom_range(99) < 90);
		drain();
	endtask

	// Random small mazes until the phase has sent its share of cells.
	task automatic test_random_mazes(int sidle, int rstall, int quota);
		int rows, cols, n, i, open_pct, stop_at;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		stop_at = cells_sent + quota;
		while (cells_sent < stop_at) begin
			rows = $urandom_range(6, 1);
			cols = $urandom_range(6, 1);
			if ($urandom_range(9) == 0)
				set_maze(rows, cols, $urandom_range(31), $urandom_range(31),
					$urandom_range(31), $urandom_range(31));
			else
				set_maze(rows, cols, $urandom_range(rows - 1), $urandom_range(cols - 1),
					$urandom_range(rows - 1), $urandom_range(cols - 1));
			open_pct = $urandom_range(95, 50);
			n = rows * cols;
			for (i = 0; i < n; i++) send_cell($urandom_range(99) < open_pct);
			drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker: compare each accepted word with the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		path_word_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got = {status, node_index, node_row, node_col, last};
			if (path_q.size() == 0) begin
				$display("%0t: unexpected word st=%0d idx=%0d row=%0d col=%0d last=%0d",
					$time, got.st, got.idx, got.row, got.col, got.lst);
				err_count++;
			end else begin
				want = path_q.pop_front();
				if (got !== want) begin
					$display("%0t: expected st=%0d idx=%0d row=%0d col=%0d last=%0d, %s",
						$time, want.st, want.idx, want.row, want.col, want.lst, "got");
					$display("%0t: actual   st=%0d idx=%0d row=%0d col=%0d last=%0d",
						$time, got.st, got.idx, got.row, got.col, got.lst);
					err_count++;
				end
			end
		end
	end

	// Random output stall; rate set per phase.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog: count cycles where no word moves on any channel.
	always @(posedge clk) begin
		if ((cell_valid && !cell_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cell_valid     = 1'b0;
		cell_open      = 1'b0;
		result_stall   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		err_count      = 0;
		cells_sent     = 0;
		quiet_cycles   = 0;
		fill_pos       = 0;
		send_idle_pct  = 29;
		recv_stall_pct = 74;
		rows_reg = 32; cols_reg = 32;
		srow_reg = 0;  scol_reg = 0;
		erow_reg = 31; ecol_reg = 31;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wide_row();
		test_single_cell();
		test_wall_endpoints();
		test_no_path();
		test_start_outside();
		test_shrink_restart();
		test_node_overflow();
		test_full_grid();
		test_random_mazes(29, 74, 30);
		test_random_mazes(74, 29, 30);
		test_random_mazes(0, 0, 30);

		drain();
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
